/* hw/rtl/mkid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkid_pkg: shared constants and functions for key and IV derivation
// SHA-256 round constants, initial value and round helpers.
// ----------------------------------------------------------------------------
package mkid_pkg;

	localparam int KEY_WORDS = 32;
	localparam int KIDX_W = $clog2(KEY_WORDS);

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] sha_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		return k[i];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// Message schedule sigma functions.
	function automatic logic [31:0] ssig0(input logic [31:0] v);
		return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] v);
		return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
	endfunction

endpackage

/* hw/rtl/message_key_and_iv_derivation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_key_and_iv_derivation: AES key and IV from message key and auth key
// Holds the auth key in a memory and runs two SHA-256 compressions on one
// round unit to derive the AES key and IV as eight 64-bit words.
// ----------------------------------------------------------------------------
// A load word writes one auth key word into a synchronous memory. Each digest
// gathers its 36 key bytes with five registered memory reads, loads the
// padded block, runs 64 rounds of the single SHA-256 round unit and adds the
// initial value. The first result word is offered once the second digest of
// a derive is complete. The eight result words are then driven from the
// digest registers, one per accepted handshake, and the block then returns to
// idle. The round unit sets the rate, and every stall of the receiver delays
// the next derive. No new word is taken until all eight results of a derive
// are taken.
module message_key_and_iv_derivation
	import mkid_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [4:0]  key_index,
	input  logic [63:0] key_word,
	input  logic [63:0] msg_key_high,
	input  logic [63:0] msg_key_low,
	input  logic        from_server,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  word_index,
	output logic [63:0] out_word,
	output logic        last
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_ROUND = 6'b000100,
		ST_FIN   = 6'b001000,
		ST_OUT   = 6'b010000,
		ST_GAP   = 6'b100000
	} state_t;

	state_t state_q;

	// Auth key memory, one write and one registered read port.
	logic [63:0] key_mem [KEY_WORDS];
	logic [63:0] rd_data_q;
	logic [KIDX_W-1:0] rd_addr;
	logic rd_en, rd_oob, rd_oob_q;

	logic        pass_q;      // 0 = digest a, 1 = digest b
	logic        off_q;       // offset 8 when set
	logic [3:0]  rcnt_q;      // read counter, 0..5
	logic [5:0]  round_q;
	logic [2:0]  ocnt_q;
	logic [127:0] mk_q;
	logic [31:0] w_q [16];    // schedule window, w_q[0] is current word
	logic [31:0] s_q [8];
	logic [255:0] da_q, db_q;
	logic [319:0] kbuf_q;     // 40 key bytes gathered, first byte high

	// Word address of read r: base word (0 or 5) plus offset.
	logic [5:0] word_addr;
	assign word_addr = (pass_q ? 6'd5 : 6'd0) + {2'd0, rcnt_q} + {5'd0, off_q};
	assign rd_oob = (word_addr >= 6'(KEY_WORDS));
	assign rd_addr = word_addr[KIDX_W-1:0];
	assign rd_en = (state_q == ST_READ) && (rcnt_q < 4'd5);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && !kind && ({1'b0, key_index} < 6'(KEY_WORDS)))
			key_mem[key_index[KIDX_W-1:0]] <= key_word;
		if (rd_en && !rd_oob)
			rd_data_q <= key_mem[rd_addr];
	end

	// The key window spans five words: 36 bytes from a word-aligned offset.
	logic [287:0] kbytes;
	assign kbytes = kbuf_q[319:32];

	// Padded block assembled from message key and key bytes.
	logic [511:0] blk;
	always_comb begin
		if (!pass_q)
			blk = {mk_q, kbytes, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
				8'h00, 8'h00, 8'h00, 8'h00, 16'd416};
		else
			blk = {kbytes, mk_q, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
				8'h00, 8'h00, 8'h00, 8'h00, 16'd416};
	end

	// One SHA-256 round.
	logic [31:0] t1, t2, w_next;
	always_comb begin
		t1 = s_q[7] + (rotr(s_q[4], 6) ^ rotr(s_q[4], 11) ^ rotr(s_q[4], 25))
			+ ((s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6])) + sha_k(round_q) + w_q[0];
		t2 = (rotr(s_q[0], 2) ^ rotr(s_q[0], 13) ^ rotr(s_q[0], 22))
			+ ((s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]));
		w_next = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
	end

	// Final digest with initial value added.
	logic [255:0] dig;
	always_comb begin
		for (int i = 0; i < 8; i++)
			dig[255-32*i -: 32] = s_q[i] + SHA_IV[i];
	end

	// Result word selection.
	logic [63:0] res;
	always_comb begin
		case (ocnt_q)
			3'd0: res = da_q[255:192];
			3'd1: res = db_q[191:128];
			3'd2: res = db_q[127:64];
			3'd3: res = da_q[63:0];
			3'd4: res = db_q[255:192];
			3'd5: res = da_q[191:128];
			3'd6: res = da_q[127:64];
			3'd7: res = db_q[63:0];
			default: res = '0;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q <= 1'b0;
			rcnt_q <= '0;
			round_q <= '0;
			ocnt_q <= '0;
			out_valid <= 1'b0;
			rd_oob_q <= 1'b0;
		end else begin
			rd_oob_q <= rd_oob;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && kind) begin
						state_q <= ST_READ;
						pass_q <= 1'b0;
						rcnt_q <= '0;
					end
				end
				ST_READ: begin
					rcnt_q <= rcnt_q + 4'd1;
					if (rcnt_q == 4'd5)
						state_q <= ST_GAP;
				end
				ST_GAP: begin
					state_q <= ST_ROUND;
					round_q <= '0;
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!pass_q) begin
						pass_q <= 1'b1;
						rcnt_q <= '0;
						state_q <= ST_READ;
					end else begin
						state_q <= ST_OUT;
						ocnt_q <= '0;
						out_valid <= 1'b1;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						ocnt_q <= ocnt_q + 3'd1;
						if (ocnt_q == 3'd7) begin
							out_valid <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && kind) begin
			mk_q <= {msg_key_high, msg_key_low};
			off_q <= from_server;
		end
		// Read data arrives in the cycle after each address.
		if (state_q == ST_READ && rcnt_q != 4'd0)
			kbuf_q <= {kbuf_q[255:0], (rd_oob_q ? 64'd0 : rd_data_q)};
		if (state_q == ST_GAP) begin
			for (int i = 0; i < 16; i++)
				w_q[i] <= blk[511-32*i -: 32];
			for (int i = 0; i < 8; i++)
				s_q[i] <= SHA_IV[i];
		end
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= w_next;
			s_q[7] <= s_q[6]; s_q[6] <= s_q[5]; s_q[5] <= s_q[4];
			s_q[4] <= s_q[3] + t1;
			s_q[3] <= s_q[2]; s_q[2] <= s_q[1]; s_q[1] <= s_q[0];
			s_q[0] <= t1 + t2;
		end
		if (state_q == ST_FIN) begin
			if (!pass_q)
				da_q <= dig;
			else
				db_q <= dig;
		end
	end

	assign word_index = ocnt_q;
	assign out_word = res;
	assign last = (ocnt_q == 3'd7);

	// Results appear only while the sequencer is in its output phase.
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT) else $error("result outside output phase");
	// No input word is taken during a derive.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken during derive");
	// After the last word the block returns to idle.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready && !out_valid)
		else $error("no return to idle after last word");

endmodule
